>>> hw/rtl/assert_macros.svh
// Assertion macros for the port-level checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, sampled on clk, off during rst.
`define AST_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on clk, off during rst.
`define AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> hw/rtl/pbrs_pkg.sv
// Package for the piece block request scoreboard: sizes, operation codes,
// register map and the configuration struct. No dependencies.
package pbrs_pkg;
  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int ACC_W = 22;
  localparam int BLEN_MAX = 16384;
  localparam logic [7:0] CHURN_LIMIT = 8'd10;
  localparam logic [31:0] TIMEOUT_RESET = 32'd30000;
  localparam logic [14:0] BLOCK_LEN_RESET = 15'd16384;

  localparam logic [3:0] OP_INIT = 4'd0;
  localparam logic [3:0] OP_GET_TASK = 4'd1;
  localparam logic [3:0] OP_SET_DATA = 4'd2;
  localparam logic [3:0] OP_SET_ALIEN = 4'd3;
  localparam logic [3:0] OP_MARK = 4'd4;
  localparam logic [3:0] OP_UNMARK = 4'd5;
  localparam logic [3:0] OP_UNMARK_ALL = 4'd6;
  localparam logic [3:0] OP_SET_ZERO = 4'd7;
  localparam logic [3:0] OP_CLEAR_OTHERS = 4'd8;
  localparam logic [3:0] OP_CHOKE = 4'd9;
  localparam logic [3:0] OP_TIMEOUT = 4'd10;
  localparam logic [3:0] OP_IS_PENDING = 4'd11;
  localparam logic [3:0] OP_HAS_SOURCE = 4'd12;
  localparam logic [3:0] OP_LIST = 4'd13;

  localparam logic [2:0] TO_OK = 3'd0;
  localparam logic [2:0] TO_CHURN = 3'd1;
  localparam logic [2:0] TO_CHOKED = 3'd2;
  localparam logic [2:0] TO_NO_DATA = 3'd3;
  localparam logic [2:0] TO_STALLED = 3'd4;

  localparam logic REG_TIMEOUT_BASE = 1'b0;
  localparam logic REG_BLOCK_LEN = 1'b1;

  typedef struct packed {
    logic [31:0] timeout_base;
    logic [14:0] eff_len;
  } cfg_t;
endpackage

>>> hw/rtl/pbrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/pbrs_cfg.sv
// APB register file: timeout_base and block_len, with the clamped block size.
// Depends on pbrs_pkg.
module pbrs_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output pbrs_pkg::cfg_t      cfg
);
  import pbrs_pkg::*;

  logic [31:0] timeout_base;
  logic [14:0] block_len;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_base <= TIMEOUT_RESET;
      block_len <= BLOCK_LEN_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        REG_TIMEOUT_BASE: timeout_base <= pwdata;
        REG_BLOCK_LEN:    block_len <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TIMEOUT_BASE: prdata = timeout_base;
      REG_BLOCK_LEN:    prdata = {17'd0, block_len};
      default:          prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.timeout_base = timeout_base;
    if (block_len == 15'd0) begin
      cfg.eff_len = 15'd1;
    end else if (block_len > 15'(BLEN_MAX)) begin
      cfg.eff_len = 15'(BLEN_MAX);
    end else begin
      cfg.eff_len = block_len;
    end
  end
endmodule

>>> hw/rtl/pbrs_core.sv
// Sequencer and scan datapath: walks all block entries one per cycle with a
// running offset adder, updates the flags and emits results.
// Depends on pbrs_pkg and pbrs_ram.
module pbrs_core (
  input  logic               clk,
  input  logic               rst,
  input  pbrs_pkg::cfg_t     cfg,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         operation,
  input  logic [31:0]        now,
  input  logic               index_neg,
  input  logic [19:0]        offset,
  input  logic [20:0]        length,
  input  logic [31:0]        source,
  input  logic               choke_flag,
  input  logic [6:0]         limit,
  output logic               strobe,
  output logic               answer,
  output logic [2:0]         timeout_code,
  output logic [19:0]        block_offset,
  output logic [14:0]        block_length,
  output logic [6:0]         pending_total,
  output logic               finished,
  output logic               table_empty,
  output logic               too_long,
  output logic               last
);
  import pbrs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]        state;
  // latched request
  logic [3:0]        op;
  logic [31:0]       cmd_now;
  logic              cmd_neg;
  logic [19:0]       cmd_off;
  logic [20:0]       cmd_len;
  logic [31:0]       cmd_src;
  logic              cmd_chk;
  logic [6:0]        cmd_lim;
  // scan
  logic [CNT_W-1:0]  issue;
  logic              pv;
  logic [IDX_W-1:0]  p;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  acc_prev;
  logic              found;
  logic              ans;
  logic [19:0]       ro;
  logic [14:0]       rl;
  logic [6:0]        k;
  logic [CNT_W-1:0]  init_cnt;
  logic [14:0]       init_tail;
  logic [2:0]        code;
  logic              tl;
  // scoreboard state
  logic [MAX_BLOCKS-1:0] pending;
  logic [MAX_BLOCKS-1:0] held;
  logic [CNT_W-1:0]  count;
  logic [14:0]       tail;
  logic              loaded;
  logic [CNT_W-1:0]  pend_cnt;
  logic [31:0]       req_tick;
  logic [31:0]       data_tick;
  logic [31:0]       choke_tick;
  logic [7:0]        choke_ev;

  logic [31:0]       rdata;
  logic              ram_we;
  logic [31:0]       ram_wdata;
  logic [IDX_W-1:0]  raddr;

  logic              in_range;
  logic [14:0]       blen;
  logic [19:0]       soff;
  logic [ACC_W-1:0]  len_x;
  logic              off_hit;
  logic              zero_hit;
  logic              list_hit;
  logic [MAX_BLOCKS-1:0] vmask;
  logic [MAX_BLOCKS-1:0] above;
  logic              more_after;
  logic              all_held;
  logic [31:0]       tsel;
  logic [31:0]       tdiff;
  logic [8:0]        choke_up;
  logic [8:0]        unchoke_up;

  assign busy = (state != ST_IDLE);
  assign raddr = issue[IDX_W-1:0];

  pbrs_ram #(.WIDTH(32), .DEPTH(MAX_BLOCKS)) u_src (
    .clk(clk), .we(ram_we), .waddr(p), .wdata(ram_wdata),
    .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    for (int j = 0; j < MAX_BLOCKS; j++) begin
      vmask[j] = (CNT_W'(j) < count);
      above[j] = (j > int'(p));
    end
    more_after = |(pending & vmask & above);
    all_held = &(held | ~vmask);
  end

  assign in_range = ({1'b0, p} < count);
  assign blen = ({1'b0, p} + CNT_W'(1) == count) ? tail : cfg.eff_len;
  assign soff = acc[19:0];
  assign len_x = ACC_W'(cmd_len);
  assign off_hit = in_range && (soff == cmd_off);
  assign zero_hit = in_range && (soff >= cmd_off) &&
                    (ACC_W'(soff) + ACC_W'(blen) <= ACC_W'(cmd_off) + len_x);
  assign list_hit = pv && (op == OP_LIST) && in_range && pending[p] && (k < cmd_lim);

  always_comb begin
    ram_we = 1'b0;
    ram_wdata = 32'd0;
    if (state == ST_SCAN && pv) begin
      unique case (op)
        OP_INIT: ram_we = 1'b1;
        OP_SET_ALIEN: begin
          ram_we = !found && off_hit && (ACC_W'(blen) == len_x);
          ram_wdata = cmd_src;
        end
        OP_SET_ZERO: ram_we = zero_hit;
        OP_CLEAR_OTHERS: ram_we = in_range && held[p] && (rdata != cmd_src);
        default: ram_we = 1'b0;
      endcase
    end
  end

  // single subtract for the timeout check; tick chosen by choke parity
  always_comb begin
    if (!choke_ev[0]) begin
      tsel = choke_tick;
    end else if (data_tick == 32'd0) begin
      tsel = req_tick;
    end else begin
      tsel = data_tick;
    end
    tdiff = cmd_now - tsel;
    choke_up = ({1'b0, choke_ev} + 9'd2) & ~9'd1;
    unchoke_up = ({1'b0, choke_ev} + 9'd1) | 9'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      strobe <= 1'b0;
      pending <= '0;
      held <= '0;
      count <= '0;
      tail <= '0;
      loaded <= 1'b0;
      pend_cnt <= '0;
      req_tick <= '0;
      data_tick <= '0;
      choke_tick <= '0;
      choke_ev <= '0;
      issue <= '0;
      pv <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          strobe <= 1'b0;
          if (start) begin
            op <= operation;
            cmd_now <= now;
            cmd_neg <= index_neg;
            cmd_off <= offset;
            cmd_len <= length;
            cmd_src <= source;
            cmd_chk <= choke_flag;
            cmd_lim <= (limit == 7'd0) ? 7'd1 : limit;
            issue <= '0;
            pv <= 1'b0;
            acc <= '0;
            acc_prev <= '0;
            found <= 1'b0;
            ans <= 1'b0;
            ro <= '0;
            rl <= '0;
            k <= '0;
            code <= TO_OK;
            tl <= 1'b0;
            init_cnt <= '0;
            init_tail <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          strobe <= list_hit;
          if (issue < CNT_W'(MAX_BLOCKS)) begin
            issue <= issue + CNT_W'(1);
            p <= issue[IDX_W-1:0];
            pv <= 1'b1;
          end else begin
            pv <= 1'b0;
            if (!pv) begin
              state <= ST_DONE;
            end
          end
          if (pv) begin
            acc <= acc + ACC_W'(cfg.eff_len);
            acc_prev <= acc;
            unique case (op)
              OP_INIT: begin
                if (!found && acc >= len_x) begin
                  found <= 1'b1;
                  init_cnt <= CNT_W'(p);
                  init_tail <= (p == '0) ? 15'd0 : 15'(len_x - acc_prev);
                end
              end
              OP_GET_TASK: begin
                if (!found && in_range && !held[p] && !pending[p]) begin
                  found <= 1'b1;
                  pending[p] <= 1'b1;
                  pend_cnt <= pend_cnt + CNT_W'(1);
                  req_tick <= cmd_now;
                  ans <= 1'b1;
                  ro <= soff;
                  rl <= blen;
                end
              end
              OP_SET_DATA, OP_SET_ALIEN: begin
                if (!found && off_hit && (ACC_W'(blen) == len_x)) begin
                  found <= 1'b1;
                  held[p] <= 1'b1;
                  ans <= 1'b1;
                  if (op == OP_SET_DATA) begin
                    data_tick <= cmd_now;
                    if (pending[p]) begin
                      pending[p] <= 1'b0;
                      pend_cnt <= pend_cnt - CNT_W'(1);
                    end
                  end
                end
              end
              OP_MARK, OP_UNMARK, OP_IS_PENDING: begin
                if (!found && off_hit) begin
                  found <= 1'b1;
                  if (op == OP_IS_PENDING) begin
                    ans <= pending[p];
                  end else begin
                    ans <= 1'b1;
                  end
                  if (op == OP_MARK && !pending[p]) begin
                    pending[p] <= 1'b1;
                    pend_cnt <= pend_cnt + CNT_W'(1);
                  end
                  if (op == OP_UNMARK && pending[p]) begin
                    pending[p] <= 1'b0;
                    pend_cnt <= pend_cnt - CNT_W'(1);
                  end
                end
              end
              OP_SET_ZERO: begin
                if (zero_hit) begin
                  held[p] <= 1'b1;
                  ans <= 1'b1;
                end
              end
              OP_CLEAR_OTHERS: begin
                if (in_range && held[p] && (rdata != cmd_src)) begin
                  held[p] <= 1'b0;
                  ans <= 1'b1;
                end
              end
              OP_HAS_SOURCE: begin
                if (in_range && (rdata == cmd_src)) begin
                  ans <= 1'b1;
                end
              end
              OP_LIST: begin
                // emit each pending block straight away, up to the limit
                if (list_hit) begin
                  k <= k + 7'd1;
                  answer <= 1'b1;
                  timeout_code <= TO_OK;
                  block_offset <= soff;
                  block_length <= blen;
                  pending_total <= 7'(pend_cnt);
                  finished <= loaded && all_held;
                  table_empty <= !loaded;
                  too_long <= 1'b0;
                  last <= (k + 7'd1 == cmd_lim) || !more_after;
                end
              end
              default: ;
            endcase
          end
        end
        ST_DONE: begin
          strobe <= 1'b0;
          state <= ST_EMIT;
          unique case (op)
            OP_INIT: begin
              pending <= '0;
              held <= '0;
              pend_cnt <= '0;
              if (!cmd_neg && (found || acc >= len_x)) begin
                count <= found ? init_cnt : CNT_W'(MAX_BLOCKS);
                tail <= found ? init_tail : 15'(len_x - acc_prev);
                loaded <= 1'b1;
                req_tick <= '0;
                data_tick <= '0;
              end else begin
                count <= '0;
                tail <= '0;
                loaded <= 1'b0;
                tl <= !cmd_neg;
              end
            end
            OP_UNMARK_ALL: begin
              pending <= '0;
              pend_cnt <= '0;
              req_tick <= '0;
              data_tick <= '0;
            end
            OP_CHOKE: begin
              if (cmd_chk) begin
                choke_ev <= (choke_up > 9'd254) ? 8'd254 : choke_up[7:0];
                choke_tick <= cmd_now;
                data_tick <= '0;
              end else begin
                choke_ev <= (unchoke_up > 9'd255) ? 8'd255 : unchoke_up[7:0];
                req_tick <= cmd_now;
              end
            end
            OP_TIMEOUT: begin
              if (!choke_ev[0]) begin
                if (choke_ev > CHURN_LIMIT) begin
                  code <= TO_CHURN;
                end else if (tdiff > cfg.timeout_base) begin
                  code <= TO_CHOKED;
                end
              end else if (req_tick != 32'd0 && tdiff > cfg.timeout_base) begin
                code <= (data_tick == 32'd0) ? TO_NO_DATA : TO_STALLED;
              end
            end
            default: ;
          endcase
        end
        ST_EMIT: begin
          state <= ST_IDLE;
          strobe <= (op != OP_LIST) || (k == 7'd0);
          if (op != OP_LIST || k == 7'd0) begin
            answer <= ans;
            timeout_code <= code;
            block_offset <= ro;
            block_length <= rl;
            pending_total <= 7'(pend_cnt);
            finished <= loaded && all_held;
            table_empty <= !loaded;
            too_long <= tl;
            last <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
          strobe <= 1'b0;
        end
      endcase
    end
  end
endmodule

>>> hw/rtl/piece_block_request_scoreboard.sv
// Top level of the piece block request scoreboard.
// Depends on pbrs_pkg, pbrs_cfg, pbrs_core (and pbrs_ram below it).
//
//  channel   handshake                      payload
//  request   start / busy                   operation now piece_index offset ...
//  result    strobe (one cycle, no stall)   answer timeout_code block_* ... last
//  config    APB psel penable pwrite pready paddr pwdata prdata
//
// busy is high for the whole scan: the source RAM read is primed, then one entry is
// read and one offset added per cycle, then come a drain step, a settle state and an
// emit state. The next request is taken once busy has fallen.
// List results leave during the scan, one per pending block up to the limit.
// rst is synchronous: it clears the table, tick state and registers.
// The receiver cannot stall; busy falls with or after the final result.
module piece_block_request_scoreboard (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         operation,
  input  logic [31:0]        now,
  input  logic signed [20:0] piece_index,
  input  logic [19:0]        offset,
  input  logic [20:0]        length,
  input  logic [31:0]        source,
  input  logic               choke_flag,
  input  logic [6:0]         limit,
  output logic               strobe,
  output logic               answer,
  output logic [2:0]         timeout_code,
  output logic [19:0]        block_offset,
  output logic [14:0]        block_length,
  output logic [6:0]         pending_total,
  output logic               finished,
  output logic               table_empty,
  output logic               too_long,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pbrs_pkg::*;

  cfg_t cfg;

  pbrs_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cfg(cfg)
  );

  pbrs_core u_core (
    .clk(clk), .rst(rst), .cfg(cfg), .start(start), .busy(busy),
    .operation(operation), .now(now), .index_neg(piece_index[20]),
    .offset(offset), .length(length), .source(source),
    .choke_flag(choke_flag), .limit(limit), .strobe(strobe),
    .answer(answer), .timeout_code(timeout_code),
    .block_offset(block_offset), .block_length(block_length),
    .pending_total(pending_total), .finished(finished),
    .table_empty(table_empty), .too_long(too_long), .last(last)
  );
endmodule

>>> hw/rtl/pbrs_checker.sv
// Port-level checker for the scoreboard, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module pbrs_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic strobe,
  input logic last,
  input logic too_long,
  input logic table_empty,
  input logic finished
);
  `AST_NEXT(a_take, start && !busy, busy, "request taken but block not busy")
  `AST_NEXT(a_more, strobe && !last, busy, "idle before last result")
  `AST_NEXT(a_gap, strobe && last, !strobe, "result after last")
  `AST_NOW(a_long, strobe && too_long, table_empty, "too_long with table loaded")
  `AST_NOW(a_fin, strobe && finished, !table_empty, "finished with empty table")
endmodule

bind piece_block_request_scoreboard pbrs_checker u_pbrs_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .strobe(strobe),
  .last(last), .too_long(too_long), .table_empty(table_empty),
  .finished(finished)
);

>>> tb/tb_piece_block_request_scoreboard.sv
// Self-checking testbench for piece_block_request_scoreboard: drives requests and APB writes,
// predicts every result in a behavioural scoreboard model and compares on each strobe.
// Depends on pbrs_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb_piece_block_request_scoreboard;
  import pbrs_pkg::*;

  typedef struct {
    logic [3:0]         op;
    logic [31:0]        now;
    logic signed [20:0] pidx;
    logic [19:0]        off;
    logic [20:0]        len;
    logic [31:0]        src;
    logic               chk;
    logic [6:0]         lim;
  } req_t;

  typedef struct {
    logic        answer;
    logic [2:0]  code;
    logic [19:0] boff;
    logic [14:0] blen;
    logic [6:0]  ptotal;
    logic        fin;
    logic        empty;
    logic        toolong;
    logic        lastf;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [3:0] operation = '0;
  logic [31:0] now = '0;
  logic signed [20:0] piece_index = '0;
  logic [19:0] offset = '0;
  logic [20:0] length = '0;
  logic [31:0] source = '0;
  logic choke_flag = 1'b0;
  logic [6:0] limit = '0;
  logic strobe, answer, finished, table_empty, too_long, last, pready;
  logic [2:0] timeout_code;
  logic [19:0] block_offset;
  logic [14:0] block_length;
  logic [6:0] pending_total;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;

  piece_block_request_scoreboard uut (.*);

  always #5 clk = ~clk;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   mismatches = 0;

  function automatic void add_req(req_t q);
    pending_reqs.insert(pending_reqs.size(), q);
  endfunction

  // scoreboard model state
  logic [31:0] m_timeout;
  logic [14:0] m_blen;
  logic        m_pend[MAX_BLOCKS];
  logic        m_held[MAX_BLOCKS];
  logic [31:0] m_src[MAX_BLOCKS];
  int unsigned m_count, m_tail, m_pcount;
  logic        m_loaded;
  logic [31:0] m_req_tick, m_data_tick, m_choke_tick;
  int unsigned m_chokes;

  function automatic int unsigned eff_len();
    if (m_blen == 0) return 1;
    if (m_blen > BLEN_MAX) return BLEN_MAX;
    return m_blen;
  endfunction

  function automatic int unsigned blk_off(int unsigned i);
    return (i * eff_len()) & 32'hFFFFF;
  endfunction

  function automatic int unsigned blk_len(int unsigned i);
    return (i + 1 == m_count) ? m_tail : eff_len();
  endfunction

  function automatic logic all_held();
    if (!m_loaded) return 1'b0;
    for (int unsigned i = 0; i < m_count; i++) if (!m_held[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      m_pend[i] = 1'b0;
      m_held[i] = 1'b0;
    end
    m_count = 0; m_tail = 0; m_loaded = 1'b0; m_pcount = 0;
  endfunction

  function automatic void push_result(logic a, logic [2:0] c, int unsigned o, int unsigned l,
                                      logic t, logic lf);
    res_t r;
    r.answer = a; r.code = c; r.boff = o[19:0]; r.blen = l[14:0];
    r.ptotal = m_pcount[6:0]; r.fin = all_held(); r.empty = !m_loaded;
    r.toolong = t; r.lastf = lf;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic int find_block(logic [19:0] o);
    for (int unsigned i = 0; i < m_count; i++) if (blk_off(i) == o) return i;
    return -1;
  endfunction

  function automatic void predict_request(req_t q);
    logic a, t;
    logic [2:0] c;
    int unsigned ro, rl, bl, cnt, n, lim, total, k;
    int b;
    longint unsigned s;
    a = 0; t = 0; c = TO_OK; ro = 0; rl = 0;
    case (q.op)
      OP_INIT: begin
        if (q.pidx < 0) clear_table();
        else begin
          bl = eff_len();
          cnt = (q.len + bl - 1) / bl;
          clear_table();
          if (cnt > MAX_BLOCKS) t = 1;
          else begin
            m_count = cnt;
            m_tail = cnt ? q.len - (cnt - 1) * bl : 0;
            for (int unsigned i = 0; i < cnt; i++) m_src[i] = '0;
            m_loaded = 1; m_data_tick = '0; m_req_tick = '0;
          end
        end
      end
      OP_GET_TASK: begin
        for (int unsigned i = 0; i < m_count; i++) begin
          if (!m_held[i] && !m_pend[i]) begin
            m_pend[i] = 1; m_pcount++; m_req_tick = q.now;
            a = 1; ro = blk_off(i); rl = blk_len(i);
            break;
          end
        end
      end
      OP_SET_DATA, OP_SET_ALIEN: begin
        for (int unsigned i = 0; i < m_count; i++) begin
          if (blk_off(i) == q.off && blk_len(i) == q.len) begin
            m_held[i] = 1;
            if (q.op == OP_SET_DATA) begin
              if (m_pend[i]) begin m_pend[i] = 0; m_pcount--; end
              m_data_tick = q.now;
            end else m_src[i] = q.src;
            a = 1;
            break;
          end
        end
      end
      OP_MARK, OP_UNMARK: begin
        b = find_block(q.off);
        if (b >= 0) begin
          a = 1;
          if (q.op == OP_MARK && !m_pend[b]) begin m_pend[b] = 1; m_pcount++; end
          if (q.op == OP_UNMARK && m_pend[b]) begin m_pend[b] = 0; m_pcount--; end
        end
      end
      OP_UNMARK_ALL: begin
        for (int i = 0; i < MAX_BLOCKS; i++) m_pend[i] = 0;
        m_pcount = 0; m_req_tick = '0; m_data_tick = '0;
      end
      OP_SET_ZERO: begin
        for (int unsigned i = 0; i < m_count; i++) begin
          s = blk_off(i);
          if (s >= q.off && s + blk_len(i) <= longint'(q.off) + q.len) begin
            m_held[i] = 1; m_src[i] = '0; a = 1;
          end
        end
      end
      OP_CLEAR_OTHERS: begin
        for (int unsigned i = 0; i < m_count; i++) begin
          if (m_src[i] != q.src && m_held[i]) begin
            m_held[i] = 0; m_src[i] = '0; a = 1;
          end
        end
      end
      OP_CHOKE: begin
        if (q.chk) begin
          n = (m_chokes + 2) & ~32'd1;
          m_chokes = (n > 254) ? 254 : n;
          m_choke_tick = q.now; m_data_tick = '0;
        end else begin
          n = (m_chokes + 1) | 32'd1;
          m_chokes = (n > 255) ? 255 : n;
          m_req_tick = q.now;
        end
      end
      OP_TIMEOUT: begin
        if (m_chokes[0] == 0) begin
          if (m_chokes > CHURN_LIMIT) c = TO_CHURN;
          else if (32'(q.now - m_choke_tick) > m_timeout) c = TO_CHOKED;
        end else if (m_req_tick != 0) begin
          if (m_data_tick == 0) begin
            if (32'(q.now - m_req_tick) > m_timeout) c = TO_NO_DATA;
          end else if (32'(q.now - m_data_tick) > m_timeout) c = TO_STALLED;
        end
      end
      OP_IS_PENDING: begin
        b = find_block(q.off);
        if (b >= 0) a = m_pend[b];
      end
      OP_HAS_SOURCE: begin
        for (int unsigned i = 0; i < m_count; i++)
          if (m_src[i] == q.src) begin a = 1; break; end
      end
      OP_LIST: begin
        lim = (q.lim == 0) ? 1 : q.lim;
        total = 0;
        for (int unsigned i = 0; i < m_count; i++) if (m_pend[i] && total < lim) total++;
        if (total != 0) begin
          k = 0;
          for (int unsigned i = 0; i < m_count && k < total; i++) begin
            if (m_pend[i]) begin
              push_result(1, TO_OK, blk_off(i), blk_len(i), 0, k + 1 == total);
              k++;
            end
          end
          return;
        end
      end
      default: ;
    endcase
    push_result(a, c, ro, rl, t, 1);
  endfunction

  // request driver
  req_t cur;
  int   gap_left = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 5);
    return $urandom_range(20, 200);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) predict_request(cur);
      if (start && busy) begin
        // hold until taken
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur = pending_reqs.pop_front();
        operation <= cur.op; now <= cur.now; piece_index <= cur.pidx;
        offset <= cur.off; length <= cur.len; source <= cur.src;
        choke_flag <= cur.chk; limit <= cur.lim;
        start <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    res_t e;
    if (!rst && strobe) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        e = expected_results.pop_front();
        if (answer !== e.answer || timeout_code !== e.code || block_offset !== e.boff ||
            block_length !== e.blen || pending_total !== e.ptotal || finished !== e.fin ||
            table_empty !== e.empty || too_long !== e.toolong || last !== e.lastf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp a=%b c=%0d o=%0d l=%0d p=%0d f=%b e=%b t=%b z=%b",
                     $realtime, e.answer, e.code, e.boff, e.blen, e.ptotal, e.fin, e.empty,
                     e.toolong, e.lastf, "\n             got a=%b c=%0d o=%0d l=%0d p=%0d ",
                     answer, timeout_code, block_offset, block_length, pending_total,
                     "f=%b e=%b t=%b z=%b", finished, table_empty, too_long, last);
        end
      end
    end
  end

  // stimulus
  logic [31:0] tick = 32'd1000;
  int unsigned cur_bl = BLEN_MAX;
  logic [31:0] src_pool[4] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0A00_0001};

  function automatic req_t mk(logic [3:0] op, logic [19:0] off, logic [20:0] len);
    req_t q;
    q.op = op; q.now = tick; q.pidx = 21'sd5; q.off = off; q.len = len;
    q.src = '0; q.chk = 1'b0; q.lim = 7'd64;
    return q;
  endfunction

  function automatic logic [31:0] pick_src();
    if ($urandom_range(0, 99) < 85) return src_pool[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  function automatic req_t rand_req();
    req_t q;
    int r;
    int unsigned k;
    r = $urandom_range(0, 99);
    if (r < 6) tick = $urandom;
    else if (r < 30) tick = tick + $urandom_range(0, 40000);
    else tick = tick + $urandom_range(0, 300);
    k = $urandom_range(0, 66);
    q = mk(4'($urandom_range(1, 13)), 20'(k * cur_bl), 21'(cur_bl));
    q.src = pick_src();
    q.chk = 1'($urandom_range(0, 1));
    q.lim = 7'($urandom_range(0, 127));
    q.pidx = 21'($urandom_range(0, 20'hFFFFF));
    r = $urandom_range(0, 99);
    if (r < 9) begin
      q.op = OP_INIT;
      q.len = 21'($urandom_range(0, 64 * cur_bl));
      if ($urandom_range(0, 9) == 0) q.len = 21'($urandom);
      if ($urandom_range(0, 9) == 0) q.pidx = -21'sd1 - 21'($urandom_range(0, 20'hFFFFF));
    end else if (r < 12) q.op = 4'($urandom_range(14, 15));
    if ($urandom_range(0, 99) < 12) q.off = 20'($urandom);
    if (q.op == OP_SET_DATA || q.op == OP_SET_ALIEN) begin
      if ($urandom_range(0, 3) == 0) q.len = 21'($urandom_range(0, cur_bl));
    end else if (q.op == OP_SET_ZERO) begin
      q.len = 21'($urandom_range(0, 8) * cur_bl + $urandom_range(0, 1));
    end
    if ($urandom_range(0, 99) < 8) q.len = 21'($urandom);
    if ($urandom_range(0, 99) < 3) q.now = 32'h0;
    return q;
  endfunction

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr[2] == REG_TIMEOUT_BASE) m_timeout = data;
    else m_blen = data[14:0];
  endtask

  task automatic drain_all();
    while (pending_reqs.size() != 0 || start || gap_left != 0) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] tmo, logic [31:0] bl);
    drain_all();
    apb_write({REG_TIMEOUT_BASE, 2'b00}, tmo);
    apb_write({REG_BLOCK_LEN, 2'b00}, bl);
    cur_bl = (bl[14:0] == 0) ? 1 : (bl[14:0] > BLEN_MAX) ? BLEN_MAX : 32'(bl[14:0]);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) add_req(rand_req());
  endtask

  initial begin
    req_t q;
    m_timeout = TIMEOUT_RESET; m_blen = BLOCK_LEN_RESET;
    clear_table();
    for (int i = 0; i < MAX_BLOCKS; i++) m_src[i] = '0;
    m_req_tick = '0; m_data_tick = '0; m_choke_tick = '0; m_chokes = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    set_config(32'd100, 32'd1000);
    // directed: empty table, bad inits, then a short piece with a short tail
    add_req(mk(OP_GET_TASK, 0, 0));
    add_req(mk(OP_TIMEOUT, 0, 0));
    q = mk(OP_INIT, 0, 21'd65001); add_req(q);
    q = mk(OP_INIT, 0, 21'd0); add_req(q);
    q = mk(OP_INIT, 0, 21'd3500); q.pidx = -21'sd1; add_req(q);
    q = mk(OP_INIT, 0, 21'd3500); q.pidx = 21'sd1048575; add_req(q);
    add_req(mk(OP_GET_TASK, 0, 0));
    add_req(mk(OP_GET_TASK, 0, 0));
    q = mk(OP_LIST, 0, 0); q.lim = 0; add_req(q);
    q = mk(OP_LIST, 0, 0); q.lim = 7'd127; add_req(q);
    add_req(mk(OP_SET_DATA, 20'd0, 21'd1000));
    add_req(mk(OP_IS_PENDING, 20'd1000, 0));
    q = mk(OP_SET_ALIEN, 20'd3000, 21'd500); q.src = 32'hFFFF_FFFF; add_req(q);
    q = mk(OP_HAS_SOURCE, 0, 0); q.src = 32'hFFFF_FFFF; add_req(q);
    add_req(mk(OP_MARK, 20'd2000, 0));
    add_req(mk(OP_UNMARK, 20'd1000, 0));
    add_req(mk(OP_SET_ZERO, 20'd1000, 21'd2000));
    q = mk(OP_CLEAR_OTHERS, 0, 0); q.src = 32'h0; add_req(q);
    q = mk(OP_CHOKE, 0, 0); q.chk = 1; add_req(q);
    q = mk(OP_TIMEOUT, 0, 0); q.now = 32'hFFFF_FFFF; add_req(q);
    q = mk(OP_CHOKE, 0, 0); q.chk = 0; add_req(q);
    q = mk(OP_TIMEOUT, 0, 0); q.now = 32'h0000_0050; add_req(q);
    add_req(mk(OP_UNMARK_ALL, 0, 0));
    add_req(mk(4'd14, 20'hFFFFF, 21'h1FFFFF));
    add_req(mk(4'd15, 0, 0));

    set_config(32'd30000, 32'd16384);
    random_phase(50);
    set_config(32'd0, 32'd1);
    random_phase(50);
    set_config(32'hFFFF_FFFF, 32'd16);
    random_phase(50);
    // reinterpret the loaded table with an out-of-range size, then zero size
    set_config(32'd500, 32'h7FFF);
    random_phase(40);
    set_config(32'd200, 32'd0);
    random_phase(40);
    set_config(32'd5000, 32'd7);
    random_phase(50);
    // run the choke count into saturation, then mix in unchokes at the top
    for (int i = 0; i < 140; i++) begin
      q = mk(OP_CHOKE, 0, 0);
      q.chk = (i < 130) ? 1'b1 : 1'($urandom_range(0, 1));
      tick = tick + $urandom_range(0, 100); q.now = tick;
      add_req(q);
    end
    random_phase(25);

    drain_all();
    if (mismatches == 0 && expected_results.size() == 0)
      $display("tb_piece_block_request_scoreboard passed");
    else
      $display("tb_piece_block_request_scoreboard failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_piece_block_request_scoreboard failed");
    $finish;
  end
endmodule

>>> piece_block_request_scoreboard.f
+incdir+hw/rtl
hw/rtl/pbrs_pkg.sv
hw/rtl/pbrs_ram.sv
hw/rtl/pbrs_cfg.sv
hw/rtl/pbrs_core.sv
hw/rtl/piece_block_request_scoreboard.sv
hw/rtl/pbrs_checker.sv
tb/tb_piece_block_request_scoreboard.sv
